// ----- rtl/core/chte_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chte_pkg
// Shared types and codes of the chained hash table engine.
// ----------------------------------------------------------------------------
package chte_pkg;

  typedef enum logic [1:0] {
    MODE_ADD   = 2'd0,
    MODE_FIND  = 2'd1,
    MODE_REM   = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_MISS     = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_RESERVED = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_SLOT,
    ST_HEAD,
    ST_CHK,
    ST_LINK,
    ST_DONE
  } state_e;

  localparam int unsigned CfgBits  = 9;
  localparam int unsigned WordBits = 32;
  localparam int unsigned DivSteps = 16;

endpackage

// ----- rtl/core/chained_hash_table_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_table_engine
// Separate-chaining hash table over a fixed entry pool.
// ----------------------------------------------------------------------------
// Each input transaction is an add, find, remove or statistics clear and
// returns exactly one result transaction. The slot is |hash| rem n, where
// n is slots_in_use clamped to 1..min(SLOTS, 511); a radix-4 restoring
// divider produces it. The chains live in two synchronous memories with
// registered reads: a slot memory holding head and tail of each chain,
// and an entry memory holding key, data and link. The block works on one
// item at a time. Clear and full-pool add go straight to the result;
// other items run the divider and read the slot, find and remove then
// walk the chain, and add to a non-empty chain or remove of a non-head
// entry also rewrite the preceding entry's link. The memory read port
// walks one chain entry per cycle. After reset, a clearing pass over
// max(SLOTS, POOL_ENTRIES) addresses nulls the slot memory and builds the
// free list; input is stalled meanwhile, configuration writes are taken.
// A finished result waits in the output register without holding off
// the next input transaction.
module chained_hash_table_engine
  import chte_pkg::*;
#(
  parameter int unsigned SLOTS        = 256,
  parameter int unsigned POOL_ENTRIES = 1024,
  parameter int unsigned KEY_BITS     = 32,
  parameter int unsigned DATA_BITS    = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgBits-1:0]  slots_in_use_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          mode_i,
  input  logic [31:0]         key_i,
  input  logic signed [31:0]  hash_value_i,
  input  logic [31:0]         entry_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          status_o,
  output logic [31:0]         found_data_o,
  output logic [31:0]         find_count_o,
  output logic [31:0]         compare_count_o,
  output logic [31:0]         empty_slot_count_o,
  output logic [31:0]         miss_count_o
);

  localparam int unsigned SW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned PW   = $clog2(POOL_ENTRIES);
  localparam int unsigned EW   = $clog2(POOL_ENTRIES + 1);
  localparam int unsigned KSW  = (KEY_BITS < WordBits) ? KEY_BITS : WordBits;
  localparam int unsigned DSW  = (DATA_BITS < WordBits) ? DATA_BITS : WordBits;
  localparam int unsigned MAXN = (SLOTS > POOL_ENTRIES) ? SLOTS : POOL_ENTRIES;
  localparam int unsigned MW   = $clog2(MAXN);
  localparam int unsigned NRST = (SLOTS < 256) ? SLOTS : 256;
  localparam int unsigned NMAX = (SLOTS < 511) ? SLOTS : 511;
  localparam logic [EW-1:0] NullRef = EW'(POOL_ENTRIES);

  // Slot memory: {head, tail}.
  logic [2*EW-1:0] slot_mem [SLOTS];
  logic [KSW-1:0]  key_mem  [POOL_ENTRIES];
  logic [DSW-1:0]  data_mem [POOL_ENTRIES];
  logic [EW-1:0]   link_mem [POOL_ENTRIES];

  logic            slot_re, slot_we;
  logic [SW-1:0]   slot_addr;
  logic [2*EW-1:0] slot_wdata, slot_rd_q;
  logic            ent_re, kd_we, link_we;
  logic [PW-1:0]   ent_raddr, kd_waddr, link_waddr;
  logic [EW-1:0]   link_wdata;
  logic [KSW-1:0]  key_rd_q;
  logic [DSW-1:0]  data_rd_q;
  logic [EW-1:0]   link_rd_q;

  state_e          state_q, state_d;
  logic [1:0]      mode_q, mode_d;
  logic [KSW-1:0]  key_q, key_d;
  logic [DSW-1:0]  dat_q, dat_d;
  logic [31:0]     mag_q, mag_d;
  logic [CfgBits-1:0] rem_q, rem_d, n_q;
  logic [3:0]      cnt_q, cnt_d;
  logic [SW-1:0]   slot_q, slot_d;
  logic [EW-1:0]   cur_q, cur_d, prev_q, prev_d, free_q, free_d;
  logic [EW-1:0]   lw_addr_q, lw_addr_d, lw_val_q, lw_val_d;
  logic [31:0]     stat_q [4];
  logic [31:0]     stat_d [4];
  logic [1:0]      res_status_q, res_status_d;
  logic [DSW-1:0]  res_found_q, res_found_d;
  logic [MW-1:0]   clr_q, clr_d;
  logic            out_valid_q, out_valid_d, out_load;
  logic [1:0]      status_q;
  logic [31:0]     found_q, fc_q, cc_q, ec_q, mc_q;

  logic            in_accept;
  logic [CfgBits:0] r1, r2;
  logic [CfgBits-1:0] r1n, r2n;
  logic [EW-1:0]   head_rd, tail_rd, new_head, new_tail;
  logic            key_match;

  assign in_accept  = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  assign head_rd   = slot_rd_q[2*EW-1:EW];
  assign tail_rd   = slot_rd_q[EW-1:0];
  assign key_match = (key_rd_q == key_q);

  // Two restoring steps of |hash| rem n per cycle.
  always_comb begin
    r1  = {rem_q, mag_q[31]};
    r1n = (r1 >= {1'b0, n_q}) ? CfgBits'(r1 - {1'b0, n_q}) : r1[CfgBits-1:0];
    r2  = {r1n, mag_q[30]};
    r2n = (r2 >= {1'b0, n_q}) ? CfgBits'(r2 - {1'b0, n_q}) : r2[CfgBits-1:0];
  end

  // Divisor register, clamped to 1..min(SLOTS, 511) on write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= CfgBits'(NRST);
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (slots_in_use_i == '0) begin
        n_q <= CfgBits'(1);
      end else if (32'(slots_in_use_i) > NMAX) begin
        n_q <= CfgBits'(NMAX);
      end else begin
        n_q <= slots_in_use_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_addr] <= slot_wdata;
    end
    if (slot_re) begin
      slot_rd_q <= slot_mem[slot_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (kd_we) begin
      key_mem[kd_waddr]  <= key_q;
      data_mem[kd_waddr] <= dat_q;
    end
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (ent_re) begin
      key_rd_q  <= key_mem[ent_raddr];
      data_rd_q <= data_mem[ent_raddr];
      link_rd_q <= link_mem[ent_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      free_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        stat_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
      for (int i = 0; i < 4; i++) begin
        stat_q[i] <= stat_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    key_q        <= key_d;
    dat_q        <= dat_d;
    mag_q        <= mag_d;
    rem_q        <= rem_d;
    cnt_q        <= cnt_d;
    slot_q       <= slot_d;
    cur_q        <= cur_d;
    prev_q       <= prev_d;
    lw_addr_q    <= lw_addr_d;
    lw_val_q     <= lw_val_d;
    res_status_q <= res_status_d;
    res_found_q  <= res_found_d;
    if (out_load) begin
      status_q <= res_status_q;
      found_q  <= 32'(res_found_q);
      fc_q     <= stat_q[0];
      cc_q     <= stat_q[1];
      ec_q     <= stat_q[2];
      mc_q     <= stat_q[3];
    end
  end

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    free_d       = free_q;
    mode_d       = mode_q;
    key_d        = key_q;
    dat_d        = dat_q;
    mag_d        = mag_q;
    rem_d        = rem_q;
    cnt_d        = cnt_q;
    slot_d       = slot_q;
    cur_d        = cur_q;
    prev_d       = prev_q;
    lw_addr_d    = lw_addr_q;
    lw_val_d     = lw_val_q;
    res_status_d = res_status_q;
    res_found_d  = res_found_q;
    for (int i = 0; i < 4; i++) begin
      stat_d[i] = stat_q[i];
    end
    slot_re    = 1'b0;
    slot_we    = 1'b0;
    slot_addr  = slot_q;
    slot_wdata = slot_rd_q;
    ent_re     = 1'b0;
    ent_raddr  = cur_q[PW-1:0];
    kd_we      = 1'b0;
    kd_waddr   = free_q[PW-1:0];
    link_we    = 1'b0;
    link_waddr = lw_addr_q[PW-1:0];
    link_wdata = lw_val_q;
    new_head   = head_rd;
    new_tail   = tail_rd;
    out_load   = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      ST_CLEAR: begin
        // Null every slot and chain entry i to entry i+1.
        if (32'(clr_q) < SLOTS) begin
          slot_we    = 1'b1;
          slot_addr  = SW'(clr_q);
          slot_wdata = {NullRef, NullRef};
        end
        if (32'(clr_q) < POOL_ENTRIES) begin
          link_we    = 1'b1;
          link_waddr = PW'(clr_q);
          link_wdata = EW'(32'(clr_q) + 32'd1);
        end
        clr_d = clr_q + 1'b1;
        if (32'(clr_q) == MAXN - 1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          mode_d       = mode_i;
          key_d        = key_i[KSW-1:0];
          dat_d        = entry_data_i[DSW-1:0];
          mag_d        = hash_value_i[31] ? 32'(-hash_value_i) : 32'(hash_value_i);
          rem_d        = '0;
          cnt_d        = '0;
          res_status_d = STAT_OK;
          res_found_d  = '0;
          if (mode_i == MODE_CLEAR) begin
            for (int i = 0; i < 4; i++) begin
              stat_d[i] = '0;
            end
            state_d = ST_DONE;
          end else if (mode_i == MODE_ADD && free_q == NullRef) begin
            res_status_d = STAT_FULL;
            state_d      = ST_DONE;
          end else begin
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        mag_d = {mag_q[29:0], 2'b00};
        rem_d = r2n;
        cnt_d = cnt_q + 1'b1;
        if (32'(cnt_q) == DivSteps - 1) begin
          slot_d  = SW'(r2n);
          state_d = ST_SLOT;
        end
      end
      ST_SLOT: begin
        // Fetch the slot word; for add also the next free entry.
        slot_re   = 1'b1;
        ent_re    = (mode_q == MODE_ADD);
        ent_raddr = free_q[PW-1:0];
        state_d   = ST_HEAD;
      end
      ST_HEAD: begin
        if (mode_q == MODE_ADD) begin
          free_d     = link_rd_q;
          kd_we      = 1'b1;
          link_we    = 1'b1;
          link_waddr = free_q[PW-1:0];
          link_wdata = NullRef;
          slot_we    = 1'b1;
          slot_wdata = {(tail_rd != NullRef) ? head_rd : free_q, free_q};
          if (tail_rd != NullRef) begin
            lw_addr_d = tail_rd;
            lw_val_d  = free_q;
            state_d   = ST_LINK;
          end else begin
            state_d = ST_DONE;
          end
        end else begin
          if (mode_q == MODE_FIND) begin
            stat_d[0] = stat_q[0] + 32'd1;
          end
          if (head_rd == NullRef) begin
            res_status_d = STAT_MISS;
            if (mode_q == MODE_FIND) begin
              stat_d[2] = stat_q[2] + 32'd1;
              stat_d[3] = stat_q[3] + 32'd1;
            end
            state_d = ST_DONE;
          end else begin
            ent_re    = 1'b1;
            ent_raddr = head_rd[PW-1:0];
            cur_d     = head_rd;
            prev_d    = NullRef;
            state_d   = ST_CHK;
          end
        end
      end
      ST_CHK: begin
        if (mode_q == MODE_FIND) begin
          stat_d[1] = stat_q[1] + 32'd1;
        end
        if (key_match) begin
          res_status_d = STAT_OK;
          res_found_d  = data_rd_q;
          state_d      = ST_DONE;
          if (mode_q == MODE_REM) begin
            // Unlink, fix head and tail, push the entry on the free list.
            new_head   = (prev_q != NullRef) ? head_rd : link_rd_q;
            new_tail   = (link_rd_q != NullRef) ? tail_rd : prev_q;
            slot_we    = 1'b1;
            slot_wdata = {new_head, new_tail};
            link_we    = 1'b1;
            link_waddr = cur_q[PW-1:0];
            link_wdata = free_q;
            free_d     = cur_q;
            if (prev_q != NullRef) begin
              lw_addr_d = prev_q;
              lw_val_d  = link_rd_q;
              state_d   = ST_LINK;
            end
          end
        end else if (link_rd_q != NullRef) begin
          ent_re    = 1'b1;
          ent_raddr = link_rd_q[PW-1:0];
          prev_d    = cur_q;
          cur_d     = link_rd_q;
        end else begin
          res_status_d = STAT_MISS;
          if (mode_q == MODE_FIND) begin
            stat_d[3] = stat_q[3] + 32'd1;
          end
          state_d = ST_DONE;
        end
      end
      ST_LINK: begin
        link_we = 1'b1;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        // Hand the result over once the output register is free.
        if (!out_valid_q || !out_stall_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign found_data_o       = found_q;
  assign find_count_o       = fc_q;
  assign compare_count_o    = cc_q;
  assign empty_slot_count_o = ec_q;
  assign miss_count_o       = mc_q;

endmodule

// ----- rtl/core/chte_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chte_checker
// Port-level checks of the chained hash table engine.
// ----------------------------------------------------------------------------
module chte_checker
  import chte_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  status_o,
  input logic [31:0] found_data_o
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // Go busy after taking an item.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while item in flight");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != STAT_RESERVED)
    else $error("reserved status code");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STAT_MISS || status_o == STAT_FULL)
      |-> found_data_o == '0)
    else $error("data on miss or full");

endmodule

bind chained_hash_table_engine chte_checker u_chte_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .status_o     (status_o),
  .found_data_o (found_data_o)
);
